// ===== src/cti_pkg.sv =====
// Shared types and constants of the clipped trapezoid integrator.
`timescale 1ns / 1ps
package cti_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned AreaW = 64;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw = 1;

  typedef enum logic [0:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } reg_idx_e;

  // One classified point: segment geometry relative to the previous point.
  typedef struct packed {
    logic             seg;
    logic             last;
    logic [DataW-1:0] y1;
    logic             dy_neg;
    logic [DataW:0]   dy_mag;
    logic [DataW-1:0] ua;
    logic [DataW-1:0] ub;
    logic [DataW-1:0] dx;
    logic [DataW-1:0] w;
  } seg_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;
endpackage

// ===== src/cti_front.sv =====
// Front end: keeps the previous point, clips each segment to the window.
`timescale 1ns / 1ps
module cti_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic signed [31:0]          x_value_i,
  input  logic signed [31:0]          y_value_i,
  input  logic                        last_point_i,
  input  logic signed [31:0]          range_low_i,
  input  logic signed [31:0]          range_high_i,
  output cti_pkg::seg_t               entry_o
);
  logic signed [31:0] px_q, px_d, py_q, py_d;
  logic               hp_q, hp_d;
  logic signed [31:0] xa, xb;
  logic signed [32:0] dy;
  logic               outside;

  always_comb begin
    xa      = (px_q > range_low_i) ? px_q : range_low_i;
    xb      = (x_value_i < range_high_i) ? x_value_i : range_high_i;
    outside = (x_value_i <= range_low_i) || (px_q >= range_high_i) || (xb <= xa);
    dy      = {y_value_i[31], y_value_i} - {py_q[31], py_q};
    entry_o.seg    = hp_q && !outside;
    entry_o.last   = last_point_i;
    entry_o.y1     = py_q;
    entry_o.dy_neg = dy[32];
    entry_o.dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
    entry_o.ua     = 32'(xa - px_q);
    entry_o.ub     = 32'(xb - px_q);
    entry_o.dx     = 32'(x_value_i - px_q);
    entry_o.w      = 32'(xb - xa);
  end

  always_comb begin
    px_d = px_q;
    py_d = py_q;
    hp_d = hp_q;
    if (accept_i) begin
      if (last_point_i) begin
        px_d = '0;
        py_d = '0;
        hp_d = 1'b0;
      end else begin
        px_d = x_value_i;
        py_d = y_value_i;
        hp_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      hp_q <= 1'b0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
      hp_q <= hp_d;
    end
  end
endmodule

// ===== src/cti_fifo.sv =====
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module cti_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  cti_pkg::seg_t wdata_i,
  input  logic          rd_i,
  output cti_pkg::seg_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  cti_pkg::seg_t                mem_q [cti_pkg::QDepth];
  logic [cti_pkg::QAw-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [cti_pkg::QAw:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (cti_pkg::QAw+1)'(cti_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr_i) wp_d = wp_q + 1'b1;
    if (rd_i) rp_d = rp_q + 1'b1;
    if (wr_i && !rd_i) cnt_d = cnt_q + 1'b1;
    else if (rd_i && !wr_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ===== src/cti_div.sv =====
// Two-lane radix-2 restoring divider sharing one divisor, one bit per cycle.
`timescale 1ns / 1ps
module cti_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_a_i,
  input  logic [63:0]        num_b_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic [32:0]        quo_a_o,
  output logic [32:0]        quo_b_o
);
  logic [31:0] den_q, ra_q, ra_d, rb_q, rb_d;
  logic [32:0] sa_q, sa_d, sb_q, sb_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] ta, tb;

  assign done_o  = done_q;
  assign quo_a_o = sa_q;
  assign quo_b_o = sb_q;

  always_comb begin
    ra_d   = ra_q;
    rb_d   = rb_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    ta     = {ra_q, sa_q[32]};
    tb     = {rb_q, sb_q[32]};
    if (start_i) begin
      ra_d   = {1'b0, num_a_i[63:33]};
      rb_d   = {1'b0, num_b_i[63:33]};
      sa_d   = num_a_i[32:0];
      sb_d   = num_b_i[32:0];
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ta >= {1'b0, den_q}) begin
        ra_d = 32'(ta - {1'b0, den_q});
        sa_d = {sa_q[31:0], 1'b1};
      end else begin
        ra_d = ta[31:0];
        sa_d = {sa_q[31:0], 1'b0};
      end
      if (tb >= {1'b0, den_q}) begin
        rb_d = 32'(tb - {1'b0, den_q});
        sb_d = {sb_q[31:0], 1'b1};
      end else begin
        rb_d = tb[31:0];
        sb_d = {sb_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
    ra_q <= ra_d;
    rb_q <= rb_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end
endmodule

// ===== src/cti_back.sv =====
// Back end: interpolation, trapezoid area, saturating accumulation, result register.
`timescale 1ns / 1ps
module cti_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  cti_pkg::seg_t q_data_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [63:0]   area_o,
  output logic          overflow_o
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_AREA = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e             st_q, st_d;
  cti_pkg::seg_t      it_q;
  logic [63:0]        na_q, nb_q, prod_q, acc_q, acc_d, area_q, area_d;
  logic signed [32:0] sum_q;
  logic               sat_q, sat_d, ov_q, ov_d, ovf_q, ovf_d;
  logic               dstart_q;
  logic [32:0]        qa, qb, smag;
  logic signed [33:0] ya, yb;
  logic [63:0]        term, s;
  cti_pkg::div_ctl_t  dc;

  cti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dc.start),
    .num_a_i (na_q),
    .num_b_i (nb_q),
    .den_i   (it_q.dx),
    .done_o  (dc.done),
    .quo_a_o (qa),
    .quo_b_o (qb)
  );

  // divider start is registered from S_MUL together with the products it divides
  assign dc.start   = dstart_q;
  assign q_rd_o     = (st_q == S_IDLE) && !q_empty_i;
  assign empty_o    = !ov_q;
  assign area_o     = area_q;
  assign overflow_o = ovf_q;

  always_comb begin
    ya   = {it_q.y1[31], it_q.y1[31], it_q.y1};
    yb   = ya;
    if (it_q.dy_neg) begin
      ya = ya - {1'b0, qa};
      yb = yb - {1'b0, qb};
    end else begin
      ya = ya + {1'b0, qa};
      yb = yb + {1'b0, qb};
    end
    smag = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
    term = it_q.dy_neg ? '0 : '0;
    if (sum_q[32]) term = 64'(65'd0 - ((65'(prod_q) + 65'd1) >> 1));
    else           term = prod_q >> 1;
    s    = acc_q + term;
  end

  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    sat_d  = sat_q;
    ov_d   = ov_q && !pop_i;
    area_d = area_q;
    ovf_d  = ovf_q;
    unique case (st_q)
      S_IDLE: if (!q_empty_i) st_d = q_data_i.seg ? S_MUL : S_FIN;
      S_MUL:  st_d = S_DIV;
      S_DIV:  if (dc.done) st_d = S_SUM;
      S_SUM:  st_d = S_AREA;
      S_AREA: st_d = S_ACC;
      S_ACC: begin
        if ((acc_q[63] == term[63]) && (s[63] != acc_q[63])) begin
          acc_d = acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          sat_d = 1'b1;
        end else begin
          acc_d = s;
        end
        st_d = S_FIN;
      end
      S_FIN: begin
        if (!it_q.last) begin
          st_d = S_IDLE;
        end else if (!ov_q || pop_i) begin
          area_d = acc_q;
          ovf_d  = sat_q;
          ov_d   = 1'b1;
          acc_d  = '0;
          sat_d  = 1'b0;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) it_q <= q_data_i;
    if (st_q == S_MUL) begin
      na_q <= 64'(it_q.dy_mag * it_q.ua);
      nb_q <= 64'(it_q.dy_mag * it_q.ub);
    end
    if (st_q == S_SUM) sum_q <= 33'(ya + yb);
    if (st_q == S_AREA) prod_q <= 64'(smag * it_q.w);
    area_q <= area_d;
    ovf_q  <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      ov_q     <= 1'b0;
      dstart_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      ov_q     <= ov_d;
      dstart_q <= (st_q == S_MUL);
    end
  end

`ifndef SYNTH
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !pop_i |=> ov_q && $stable(area_q)) else $error("result lost");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc.done |-> st_q == S_DIV) else $error("divider done outside wait");
  a_no_rd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |-> st_q == S_IDLE && !q_empty_i) else $error("bad queue read");
`endif
endmodule

// ===== src/clipped_trapezoid_integrator.sv =====
// Top level of the clipped trapezoid integrator.
// A point closing a clipped segment runs through the 33-step shared two-lane divider
//   in the back end, which works on one point at a time; other points skip it.
// Front accepts up to 2 points ahead through its queue while the back end works.
// Reset clears window registers, curve state and queue and marks the result empty; the result value is not reset.
`timescale 1ns / 1ps
module clipped_trapezoid_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic               last_point_i,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        area_o,
  output logic               overflow_o
);
  logic signed [31:0] lo_q, hi_q;
  cti_pkg::seg_t      fe, qd;
  logic               acc, q_rd, q_empty;

  assign acc = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cti_pkg::REG_RANGE_LOW:  lo_q <= cfg_wdata_i;
        cti_pkg::REG_RANGE_HIGH: hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (acc),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .last_point_i (last_point_i),
    .range_low_i  (lo_q),
    .range_high_i (hi_q),
    .entry_o      (fe)
  );

  cti_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (acc),
    .wdata_i (fe),
    .rd_i    (q_rd),
    .rdata_o (qd),
    .full_o  (full),
    .empty_o (q_empty)
  );

  cti_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (qd),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .area_o     (area_o),
    .overflow_o (overflow_o)
  );
endmodule
